[design/hsv_rgb_color_converter_top_macros.svh]
// ----------------------------------------------------------------------------
// HSV/RGB converter assertion macros
// Concurrent check helpers on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef HSV_RGB_COLOR_CONVERTER_TOP_MACROS_SVH
`define HSV_RGB_COLOR_CONVERTER_TOP_MACROS_SVH

// same-cycle implication
`define HRC_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define HRC_ASSERT_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[design/hrc_pkg.sv]
// ----------------------------------------------------------------------------
// HSV/RGB converter package
// Payload types, queue and divider sizes, and codes shared across the design and the testbench.
// ----------------------------------------------------------------------------
package hrc_pkg;

	localparam logic [8:0] HUE_FULL = 9'd360;
	localparam logic [8:0] SAT_FULL = 9'd100;
	localparam logic [8:0] COMP_MAX = 9'd255;

	localparam logic FUNC_HSV2RGB = 1'b0;
	localparam logic FUNC_RGB2HSV = 1'b1;

	localparam logic [2:0] SEC_0 = 3'd0;
	localparam logic [2:0] SEC_1 = 3'd1;
	localparam logic [2:0] SEC_2 = 3'd2;
	localparam logic [2:0] SEC_3 = 3'd3;
	localparam logic [2:0] SEC_4 = 3'd4;
	localparam logic [2:0] SEC_5 = 3'd5;

	localparam logic [1:0] MAX_R = 2'd0;
	localparam logic [1:0] MAX_G = 2'd1;
	localparam logic [1:0] MAX_B = 2'd2;

	localparam int DIV_NUM_W = 21;
	localparam int DIV_DEN_W = 13;
	localparam int DIV_QUO_W = 9;
	localparam int DIV_REM_W = DIV_NUM_W + 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;

	typedef struct packed {
		logic       func;
		logic [8:0] comp_a;
		logic [8:0] comp_b;
		logic [8:0] comp_c;
	} hrc_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] hue;
		logic [6:0] saturation;
		logic [7:0] brightness;
		logic       rejected;
	} hrc_out_t;

	typedef struct packed {
		logic       func;
		logic       rej;
		logic       grey;
		logic [2:0] sector;
		logic [8:0] hue;
		logic [6:0] sat;
		logic [7:0] val;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} hrc_meta_t;

	typedef struct packed {
		hrc_meta_t              meta;
		logic [DIV_NUM_W-1:0]   num0;
		logic [DIV_DEN_W-1:0]   den0;
		logic [DIV_NUM_W-1:0]   num1;
		logic [DIV_DEN_W-1:0]   den1;
		logic [DIV_NUM_W-1:0]   num2;
		logic [DIV_DEN_W-1:0]   den2;
	} hrc_req_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic pop;
	} hrc_qstat_t;

endpackage

[design/hrc_if.sv]
// ----------------------------------------------------------------------------
// HSV/RGB converter stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface hrc_in_if;
	import hrc_pkg::*;
	logic    valid;
	logic    ready;
	hrc_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hrc_out_if;
	import hrc_pkg::*;
	logic     valid;
	logic     ready;
	hrc_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/hrc_front.sv]
// ----------------------------------------------------------------------------
// HSV/RGB converter front end
// Range check, sector and max/min classification, numerator products.
// ----------------------------------------------------------------------------
module hrc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  hrc_pkg::hrc_in_t  in_data,
	output logic              in_ready,
	output logic              req_valid,
	output hrc_pkg::hrc_req_t req,
	input  logic              req_full
);
	import hrc_pkg::*;

	logic adv;
	logic vld_s1, vld_s2, vld_s3;

	// stage 1 combinational
	logic [8:0] hue0, frw;
	logic [2:0] sec;
	logic       rej;
	logic [7:0] r8, g8, b8, mx, mn;
	logic [1:0] mxsel;
	logic signed [8:0] diff;

	hrc_meta_t meta_s1, meta_s2;
	logic [5:0] fr_s1;
	logic [7:0] delta_s1, delta_s2;
	logic [1:0] mxsel_s1;
	logic signed [8:0] diff_s1;

	// stage 2 combinational
	logic [12:0] qs, ts;
	logic [14:0] pn, satn;
	logic [18:0] offd;
	logic signed [18:0] hn;
	logic [12:0] qs_s2, ts_s2;
	logic [14:0] pn_s2, satn_s2;
	logic [16:0] hn_s2;

	// stage 3 combinational
	logic [DIV_NUM_W-1:0] qn, tn;
	hrc_req_t req_d;

	assign adv       = !vld_s3 || !req_full;
	assign in_ready  = adv;
	assign req_valid = vld_s3;

	always_comb begin
		hue0 = (in_data.comp_a == HUE_FULL) ? 9'd0 : in_data.comp_a;
		if (hue0 >= 9'd300) begin
			sec = SEC_5; frw = hue0 - 9'd300;
		end else if (hue0 >= 9'd240) begin
			sec = SEC_4; frw = hue0 - 9'd240;
		end else if (hue0 >= 9'd180) begin
			sec = SEC_3; frw = hue0 - 9'd180;
		end else if (hue0 >= 9'd120) begin
			sec = SEC_2; frw = hue0 - 9'd120;
		end else if (hue0 >= 9'd60) begin
			sec = SEC_1; frw = hue0 - 9'd60;
		end else begin
			sec = SEC_0; frw = hue0;
		end
		if (in_data.func == FUNC_HSV2RGB)
			rej = (in_data.comp_a > HUE_FULL) || (in_data.comp_b > SAT_FULL) ||
				(in_data.comp_c > COMP_MAX);
		else
			rej = (in_data.comp_a > COMP_MAX) || (in_data.comp_b > COMP_MAX) ||
				(in_data.comp_c > COMP_MAX);
		r8 = in_data.comp_a[7:0];
		g8 = in_data.comp_b[7:0];
		b8 = in_data.comp_c[7:0];
		if (r8 >= g8 && r8 >= b8) begin
			mxsel = MAX_R; mx = r8;
		end else if (g8 >= b8) begin
			mxsel = MAX_G; mx = g8;
		end else begin
			mxsel = MAX_B; mx = b8;
		end
		mn = (r8 < g8) ? r8 : g8;
		if (b8 < mn)
			mn = b8;
		case (mxsel)
			MAX_R:   diff = $signed({1'b0, g8}) - $signed({1'b0, b8});
			MAX_G:   diff = $signed({1'b0, b8}) - $signed({1'b0, r8});
			default: diff = $signed({1'b0, r8}) - $signed({1'b0, g8});
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1.func   <= in_data.func;
			meta_s1.rej    <= rej;
			meta_s1.grey   <= (in_data.comp_b == 9'd0) || (in_data.comp_c == 9'd0);
			meta_s1.sector <= sec;
			meta_s1.hue    <= hue0;
			meta_s1.sat    <= in_data.comp_b[6:0];
			meta_s1.val    <= (in_data.func == FUNC_HSV2RGB) ? in_data.comp_c[7:0] : mx;
			meta_s1.r      <= r8;
			meta_s1.g      <= g8;
			meta_s1.b      <= b8;
			fr_s1          <= frw[5:0];
			delta_s1       <= mx - mn;
			mxsel_s1       <= mxsel;
			diff_s1        <= diff;
		end
	end

	always_comb begin
		qs   = 13'(fr_s1) * 13'(meta_s1.sat);
		ts   = 13'(6'd60 - fr_s1) * 13'(meta_s1.sat);
		pn   = 15'(meta_s1.val) * 15'(7'd100 - meta_s1.sat);
		satn = 15'(delta_s1) * 15'd100;
		case (mxsel_s1)
			MAX_R:   offd = 19'd0;
			MAX_G:   offd = 19'(delta_s1) * 19'd120;
			default: offd = 19'(delta_s1) * 19'd240;
		endcase
		hn = 19'sd60 * 19'(diff_s1) + $signed(offd);
		if (hn < 0)
			hn = hn + $signed(19'(delta_s1) * 19'd360);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2  <= meta_s1;
			delta_s2 <= delta_s1;
			qs_s2    <= qs;
			ts_s2    <= ts;
			pn_s2    <= pn;
			satn_s2  <= satn;
			hn_s2    <= hn[16:0];
		end
	end

	always_comb begin
		qn = 21'(meta_s2.val) * 21'(13'd6000 - qs_s2);
		tn = 21'(meta_s2.val) * 21'(13'd6000 - ts_s2);
		req_d.meta = meta_s2;
		if (meta_s2.rej) begin
			req_d.num0 = '0; req_d.den0 = 13'd1;
			req_d.num1 = '0; req_d.den1 = 13'd1;
			req_d.num2 = '0; req_d.den2 = 13'd1;
		end else if (meta_s2.func == FUNC_HSV2RGB) begin
			req_d.num0 = 21'(pn_s2); req_d.den0 = 13'd100;
			req_d.num1 = qn;         req_d.den1 = 13'd6000;
			req_d.num2 = tn;         req_d.den2 = 13'd6000;
		end else begin
			// grey: zero hue; black: zero saturation
			req_d.num0 = (delta_s2 == 8'd0) ? '0 : 21'(hn_s2);
			req_d.den0 = (delta_s2 == 8'd0) ? 13'd1 : 13'(delta_s2);
			req_d.num1 = 21'(satn_s2);
			req_d.den1 = (meta_s2.val == 8'd0) ? 13'd1 : 13'(meta_s2.val);
			req_d.num2 = '0; req_d.den2 = 13'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			req <= req_d;
	end

endmodule

[design/hrc_queue.sv]
// ----------------------------------------------------------------------------
// HSV/RGB converter request queue
// Short FIFO between front end and back end.
// ----------------------------------------------------------------------------
module hrc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hrc_pkg::hrc_req_t   wr_data,
	input  logic                pop,
	output hrc_pkg::hrc_req_t   rd_data,
	output hrc_pkg::hrc_qstat_t stat
);
	import hrc_pkg::*;

	hrc_req_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign stat.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.pop   = do_pop;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_data    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wr_data;
	end

endmodule

[design/hrc_div.sv]
// ----------------------------------------------------------------------------
// HSV/RGB converter pipelined divider
// Restoring division, one quotient bit per stage, quotient below 512.
// ----------------------------------------------------------------------------
module hrc_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hrc_pkg::DIV_NUM_W-1:0] num,
	input  logic [hrc_pkg::DIV_DEN_W-1:0] den,
	output logic [hrc_pkg::DIV_QUO_W-1:0] quo
);
	import hrc_pkg::*;

	logic [DIV_REM_W-1:0] rem_q [DIV_QUO_W];
	logic [DIV_DEN_W-1:0] den_q [DIV_QUO_W];
	logic [DIV_QUO_W-1:0] quo_q [DIV_QUO_W];

	for (genvar k = 0; k < DIV_QUO_W; k++) begin : g_stage
		logic [DIV_REM_W-1:0] rem_in, dsh;
		logic [DIV_DEN_W-1:0] den_in;
		logic [DIV_QUO_W-1:0] quo_in;
		logic                 ge;
		if (k == 0) begin : g_first
			assign rem_in = DIV_REM_W'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign den_in = den_q[k-1];
			assign quo_in = quo_q[k-1];
		end
		assign dsh = DIV_REM_W'(den_in) << (DIV_QUO_W - 1 - k);
		assign ge  = (rem_in >= dsh);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? (rem_in - dsh) : rem_in;
				den_q[k] <= den_in;
				quo_q[k] <= quo_in | (ge ? (DIV_QUO_W'(1) << (DIV_QUO_W - 1 - k)) : '0);
			end
		end
	end

	assign quo = quo_q[DIV_QUO_W-1];

endmodule

[design/hrc_back.sv]
// ----------------------------------------------------------------------------
// HSV/RGB converter back end
// Three dividers (two used by both directions), result assembly and output register.
// ----------------------------------------------------------------------------
module hrc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  hrc_pkg::hrc_req_t req,
	output logic              pop,
	output logic              out_valid,
	output hrc_pkg::hrc_out_t out_data,
	input  logic              out_ready
);
	import hrc_pkg::*;

	logic                 adv;
	logic                 vld_q [DIV_QUO_W];
	hrc_meta_t            meta_q [DIV_QUO_W];
	logic [DIV_QUO_W-1:0] quo0, quo1, quo2;
	hrc_meta_t            m;
	hrc_out_t             res;
	logic [7:0]           p, q, t;

	assign adv = !out_valid || out_ready;
	assign pop = adv && req_valid;

	hrc_div u_div0 (.clk(clk), .en(adv), .num(req.num0), .den(req.den0), .quo(quo0));
	hrc_div u_div1 (.clk(clk), .en(adv), .num(req.num1), .den(req.den1), .quo(quo1));
	hrc_div u_div2 (.clk(clk), .en(adv), .num(req.num2), .den(req.den2), .quo(quo2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_QUO_W; i++)
				vld_q[i] <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= req_valid;
			for (int i = 1; i < DIV_QUO_W; i++)
				vld_q[i] <= vld_q[i-1];
			out_valid <= vld_q[DIV_QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_q[0] <= req.meta;
			for (int i = 1; i < DIV_QUO_W; i++)
				meta_q[i] <= meta_q[i-1];
		end
	end

	assign m = meta_q[DIV_QUO_W-1];
	assign p = quo0[7:0];
	assign q = quo1[7:0];
	assign t = quo2[7:0];

	always_comb begin
		res = '0;
		if (m.rej) begin
			res.rejected = 1'b1;
		end else if (m.func == FUNC_HSV2RGB) begin
			res.hue        = m.hue;
			res.saturation = m.sat;
			res.brightness = m.val;
			if (m.grey) begin
				res.red = m.val; res.green = m.val; res.blue = m.val;
			end else begin
				case (m.sector)
					SEC_0:   begin res.red = m.val; res.green = t;     res.blue = p;     end
					SEC_1:   begin res.red = q;     res.green = m.val; res.blue = p;     end
					SEC_2:   begin res.red = p;     res.green = m.val; res.blue = t;     end
					SEC_3:   begin res.red = p;     res.green = q;     res.blue = m.val; end
					SEC_4:   begin res.red = t;     res.green = p;     res.blue = m.val; end
					default: begin res.red = m.val; res.green = p;     res.blue = q;     end
				endcase
			end
		end else begin
			res.red        = m.r;
			res.green      = m.g;
			res.blue       = m.b;
			res.hue        = quo0;
			res.saturation = quo1[6:0];
			res.brightness = m.val;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_data <= res;
	end

endmodule

[design/hsv_rgb_color_converter_top.sv]
// ----------------------------------------------------------------------------
// HSV/RGB color converter top level
// Converts HSV to RGB or RGB to HSV, one pixel per clock while the output accepts, fully pipelined.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                                   | Handshake
//  --------+-----+-------------------------------------------+-------------
//  in      | in  | func, comp_a, comp_b, comp_c              | valid/ready
//  out     | out | red, green, blue, hue, saturation,        | valid/ready
//          |     | brightness, rejected                      |
//
//  One transaction accepted per clock when the output keeps up; the path
//  runs through 3 front stages, 1 in the queue, 9 divider stages (one
//  quotient bit each) and the output register.
//  Reset clears only the valid bits and the queue pointers and count; data registers are not reset.
//  An output stall freezes the back end; the 2-entry queue absorbs the
//  front end until full, then in.ready drops.
//
module hsv_rgb_color_converter_top (
	input  logic  clk,
	input  logic  arst_n,
	hrc_in_if.sink    in,
	hrc_out_if.source out
);
	import hrc_pkg::*;

`include "hsv_rgb_color_converter_top_macros.svh"

	// front end -> queue
	hrc_req_t   f_req;
	logic       f_req_valid;
	// queue -> back end
	hrc_req_t   q_req;
	hrc_qstat_t q_stat;
	logic       b_pop;
	// every result field but the reject flag is zero
	logic       out_zero;

	// Classify the transaction and build the three division requests.
	hrc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in.valid),
		.in_data  (in.data),
		.in_ready (in.ready),
		.req_valid(f_req_valid),
		.req      (f_req),
		.req_full (q_stat.full)
	);

	// Hold requests while the back end stalls.
	hrc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_req_valid),
		.wr_data(f_req),
		.pop    (b_pop),
		.rd_data(q_req),
		.stat   (q_stat)
	);

	// Divide and assemble the result.
	hrc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(!q_stat.empty),
		.req      (q_req),
		.pop      (b_pop),
		.out_valid(out.valid),
		.out_data (out.data),
		.out_ready(out.ready)
	);

	assign out_zero = (out.data.red == 8'd0) && (out.data.green == 8'd0) &&
		(out.data.blue == 8'd0) && (out.data.hue == 9'd0) &&
		(out.data.saturation == 7'd0) && (out.data.brightness == 8'd0);

	`HRC_ASSERT_IMP(a_rej_zero, out.valid && out.data.rejected, out_zero, "rejected not zero")
	`HRC_ASSERT_IMP(a_hue_range, out.valid, out.data.hue < HUE_FULL, "hue out of range")
	`HRC_ASSERT_IMP(a_sat_range, out.valid, out.data.saturation <= 7'd100, "sat out of range")
	`HRC_ASSERT_NXT(a_queue_hold, q_stat.full && !q_stat.pop, q_stat.full, "queue lost an entry")

endmodule

[test/hsv_rgb_color_converter_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV/RGB color converter testbench
// Sends directed and random pixels in both conversion directions through the
// valid/ready input channel and checks every result against an inline
// prediction of the exact integer conversion, under several idle patterns.
// ----------------------------------------------------------------------------
module hsv_rgb_color_converter_top_tb;
	import hrc_pkg::*;

	localparam int LATENCY   = 14;
	localparam int WDOG_MAX  = 20000;

	logic clk;
	logic arst_n;

	hrc_in_if  in_ch();
	hrc_out_if out_ch();

	hsv_rgb_color_converter_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch.sink),
		.out    (out_ch.source)
	);

	// clock, 8 ns period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	hrc_out_t pending_colors[$];
	int       error_count;
	int       sent_count;
	int       checked_count;
	int       send_idle_pct;
	int       recv_stall_pct;
	bit       recv_hold;
	int       idle_cycles;

	// Predict one result: exact rational arithmetic, quotients truncated.
	function automatic hrc_out_t convert_pixel(hrc_in_t px);
		hrc_out_t   res;
		int         h, s, v, sector, fr, p, q, t, r, g, b;
		int         mx, mn, delta, num;
		res = '0;
		if (px.func == FUNC_HSV2RGB) begin
			if (px.comp_a > HUE_FULL || px.comp_b > SAT_FULL || px.comp_c > COMP_MAX) begin
				res.rejected = 1'b1;
				return res;
			end
			h = int'(px.comp_a);
			s = int'(px.comp_b);
			v = int'(px.comp_c);
			if (h == 360)
				h = 0;
			if (s == 0 || v == 0) begin
				r = v;
				g = v;
				b = v;
			end else begin
				sector = h / 60;
				fr     = h % 60;
				p = v * (100 - s) / 100;
				q = v * (6000 - fr * s) / 6000;
				t = v * (6000 - (60 - fr) * s) / 6000;
				case (sector)
					0: begin r = v; g = t; b = p; end
					1: begin r = q; g = v; b = p; end
					2: begin r = p; g = v; b = t; end
					3: begin r = p; g = q; b = v; end
					4: begin r = t; g = p; b = v; end
					default: begin r = v; g = p; b = q; end
				endcase
			end
			res.red = 8'(r); res.green = 8'(g); res.blue = 8'(b);
			res.hue = 9'(h); res.saturation = 7'(s); res.brightness = 8'(v);
		end else begin
			if (px.comp_a > COMP_MAX || px.comp_b > COMP_MAX || px.comp_c > COMP_MAX) begin
				res.rejected = 1'b1;
				return res;
			end
			r = int'(px.comp_a);
			g = int'(px.comp_b);
			b = int'(px.comp_c);
			mx = (r > g) ? r : g;
			mn = (r < g) ? r : g;
			if (b > mx) mx = b;
			if (b < mn) mn = b;
			delta = mx - mn;
			res.red = 8'(r); res.green = 8'(g); res.blue = 8'(b);
			res.brightness = 8'(mx);
			if (delta != 0) begin
				// red wins ties, then green
				if (mx == r)
					num = 60 * (g - b);
				else if (mx == g)
					num = 120 * delta + 60 * (b - r);
				else
					num = 240 * delta + 60 * (r - g);
				if (num < 0)
					num += 360 * delta;
				res.hue = 9'(num / delta);
			end
			if (mx != 0)
				res.saturation = 7'(100 * delta / mx);
		end
		return res;
	endfunction

	// Offer one pixel, with optional random idle before it; hold until accepted.
	task automatic send_pixel(logic f, logic [8:0] a, logic [8:0] b, logic [8:0] c);
		hrc_in_t px;
		px.func = f; px.comp_a = a; px.comp_b = b; px.comp_c = c;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= px;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		pending_colors.push_back(convert_pixel(px));
		sent_count++;
	endtask

	task automatic go_idle();
		in_ch.valid <= 1'b0;
	endtask

	// Pause until every expected result is back.
	task automatic drain();
		go_idle();
		while (pending_colors.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random(int n, bit legal_bias);
		logic f;
		for (int i = 0; i < n; i++) begin
			f = 1'($urandom_range(1));
			if (legal_bias && $urandom_range(9) != 0) begin
				if (f == FUNC_HSV2RGB)
					send_pixel(f, 9'($urandom_range(360)), 9'($urandom_range(100)),
						9'($urandom_range(255)));
				else
					send_pixel(f, 9'($urandom_range(255)), 9'($urandom_range(255)),
						9'($urandom_range(255)));
			end else begin
				send_pixel(f, 9'($urandom_range(511)), 9'($urandom_range(511)),
					9'($urandom_range(511)));
			end
		end
	endtask

	// Field extremes, rejection, grey, hue 360 and every sector.
	task automatic test_hsv_directed();
		send_pixel(FUNC_HSV2RGB, 9'd0, 9'd0, 9'd0);
		send_pixel(FUNC_HSV2RGB, 9'd360, 9'd100, 9'd255);
		send_pixel(FUNC_HSV2RGB, 9'd200, 9'd0, 9'd180);
		send_pixel(FUNC_HSV2RGB, 9'd200, 9'd70, 9'd0);
		for (int k = 0; k < 6; k++)
			send_pixel(FUNC_HSV2RGB, 9'(k * 60 + 37), 9'd100, 9'd255);
		send_pixel(FUNC_HSV2RGB, 9'd359, 9'd99, 9'd254);
		send_pixel(FUNC_HSV2RGB, 9'd361, 9'd50, 9'd50);
		send_pixel(FUNC_HSV2RGB, 9'd10, 9'd101, 9'd50);
		send_pixel(FUNC_HSV2RGB, 9'd10, 9'd50, 9'd256);
		send_pixel(FUNC_HSV2RGB, 9'd511, 9'd511, 9'd511);
		drain();
	endtask

	// Black, grey, each component the maximum, ties and rejection.
	task automatic test_rgb_directed();
		send_pixel(FUNC_RGB2HSV, 9'd0, 9'd0, 9'd0);
		send_pixel(FUNC_RGB2HSV, 9'd128, 9'd128, 9'd128);
		send_pixel(FUNC_RGB2HSV, 9'd255, 9'd0, 9'd1);
		send_pixel(FUNC_RGB2HSV, 9'd10, 9'd255, 9'd3);
		send_pixel(FUNC_RGB2HSV, 9'd5, 9'd7, 9'd255);
		send_pixel(FUNC_RGB2HSV, 9'd200, 9'd200, 9'd50);
		send_pixel(FUNC_RGB2HSV, 9'd256, 9'd0, 9'd0);
		send_pixel(FUNC_RGB2HSV, 9'd0, 9'd511, 9'd0);
		send_pixel(FUNC_RGB2HSV, 9'd0, 9'd0, 9'd300);
		drain();
	endtask

	// Random pixels under one idle pattern.
	task automatic test_random_phase(int idle, int stall, int n);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		send_random(n, 1'b1);
		drain();
	endtask

	// Hold the output off for a long stretch while the input keeps offering.
	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		recv_hold      = 1'b1;
		fork
			begin
				repeat (60) @(posedge clk);
				recv_hold = 1'b0;
			end
			send_random(40, 1'b1);
		join
		drain();
	endtask

	// Receiver: drive ready at each rising edge, random stalls or a hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check each result transaction against the oldest expectation.
	always @(posedge clk) begin
		hrc_out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_colors.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_ch.data);
				error_count++;
			end else begin
				want = pending_colors.pop_front();
				checked_count++;
				if (out_ch.data.red !== want.red || out_ch.data.green !== want.green ||
				    out_ch.data.blue !== want.blue || out_ch.data.hue !== want.hue ||
				    out_ch.data.saturation !== want.saturation ||
				    out_ch.data.brightness !== want.brightness ||
				    out_ch.data.rejected !== want.rejected) begin
					$display("%0t: mismatch expected %p actual %p", $time, want, out_ch.data);
					error_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				pending_colors.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		error_count    = 0;
		sent_count     = 0;
		checked_count  = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		recv_hold      = 1'b0;
		idle_cycles    = 0;
		in_ch.valid    = 1'b0;
		in_ch.data     = '0;
		arst_n         = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_hsv_directed();
		test_rgb_directed();
		test_random_phase(0, 0, 160);
		test_random_phase(78, 0, 130);
		test_random_phase(0, 78, 130);
		test_random_phase(16, 16, 130);
		test_backpressure();
		test_random_phase(0, 0, 40);

		repeat (LATENCY * 2) @(posedge clk);
		$display("Covered %0d pixels in both directions, %0d results checked,",
			sent_count, checked_count);
		$display("including rejection, grey, hue 360, black and a long output hold.");
		if (error_count == 0 && pending_colors.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
